/* src/assert_macros.svh */
// Assertion macros used by integral_histogram_builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed (next cycle)");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed (same cycle)");

`endif

/* src/ihb_pkg.sv */
// Constants, types and helper functions of the integral histogram builder.
package ihb_pkg;

    localparam int MAX_BINS   = 16;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int BIN_W   = $clog2(MAX_BINS);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int RUN_W   = 11;
    localparam int CNT_W   = 21;
    localparam int THR_W   = PIX_W + 1;
    localparam int BCNT_W  = 5;
    localparam int LWID_W  = 11;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 1;
    localparam int ADDR_W  = BIN_W + COL_W;
    localparam int MEM_DEPTH = MAX_BINS * MAX_WIDTH;

    localparam logic [CIDX_W-1:0] CFG_BIN_COUNT  = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_LINE_WIDTH = 1'd1;

    localparam logic [BCNT_W-1:0] BIN_COUNT_RST  = BCNT_W'(MAX_BINS);
    localparam logic [LWID_W-1:0] LINE_WIDTH_RST = LWID_W'(MAX_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN
    } state_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic fire;
    } ihb_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } ihb_sts_t;

    // floor(256 / (bins_m1 + 1))
    function automatic logic [THR_W-1:0] bin_span(input logic [BIN_W-1:0] bins_m1);
        logic [THR_W-1:0] w;
        unique case (bins_m1)
            4'd0:    w = 9'd256;
            4'd1:    w = 9'd128;
            4'd2:    w = 9'd85;
            4'd3:    w = 9'd64;
            4'd4:    w = 9'd51;
            4'd5:    w = 9'd42;
            4'd6:    w = 9'd36;
            4'd7:    w = 9'd32;
            4'd8:    w = 9'd28;
            4'd9:    w = 9'd25;
            4'd10:   w = 9'd23;
            4'd11:   w = 9'd21;
            4'd12:   w = 9'd19;
            4'd13:   w = 9'd18;
            4'd14:   w = 9'd17;
            4'd15:   w = 9'd16;
            default: w = 9'd16;
        endcase
        return w;
    endfunction

endpackage

/* src/ihb_stream_if.sv */
// Valid/ready channel interfaces for pixel beats and histogram result beats.
interface ihb_pix_if;
    logic                     valid;
    logic                     ready;
    logic [ihb_pkg::PIX_W-1:0] pixel;
    logic                     frame_start;

    modport source (output valid, pixel, frame_start, input ready);
    modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface ihb_res_if;
    logic                     valid;
    logic                     ready;
    logic [ihb_pkg::BIN_W-1:0] bin_index;
    logic [ihb_pkg::CNT_W-1:0] integral_count;
    logic                     last_bin;

    modport source (output valid, bin_index, integral_count, last_bin, input ready);
    modport sink   (input valid, bin_index, integral_count, last_bin, output ready);
endinterface

/* src/ihb_ctrl.sv */
// Sequencer of the integral histogram builder: accept, line store prefetch, bin sweep.
module ihb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_ready,
    input  ihb_pkg::ihb_sts_t sts,
    output ihb_pkg::ihb_cmd_t cmd
);

    ihb_pkg::state_t state_reg;
    ihb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ihb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ihb_pkg::S_IDLE:
            begin
                if (pix_valid)
                begin
                    state_next = ihb_pkg::S_PREP;
                end
            end
            ihb_pkg::S_PREP:
            begin
                state_next = ihb_pkg::S_RUN;
            end
            ihb_pkg::S_RUN:
            begin
                if (sts.out_free && sts.last)
                begin
                    state_next = ihb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ihb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pix_ready  = 1'b0;
        cmd.accept = 1'b0;
        cmd.prep   = 1'b0;
        cmd.fire   = 1'b0;
        unique case (state_reg)
            ihb_pkg::S_IDLE:
            begin
                pix_ready  = 1'b1;
                cmd.accept = pix_valid;
            end
            ihb_pkg::S_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ihb_pkg::S_RUN:
            begin
                cmd.fire = sts.out_free;
            end
            default:
            begin
                pix_ready = 1'b0;
            end
        endcase
    end

endmodule

/* src/ihb_datapath.sv */
// Datapath: config registers, positions, row counts, line store and result register.
module ihb_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ihb_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [ihb_pkg::CFG_W-1:0]   cfg_data,
    input  logic [ihb_pkg::PIX_W-1:0]   pix_pixel,
    input  logic                        pix_frame_start,
    input  ihb_pkg::ihb_cmd_t           cmd,
    output ihb_pkg::ihb_sts_t           sts,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [ihb_pkg::BIN_W-1:0]   res_bin_index,
    output logic [ihb_pkg::CNT_W-1:0]   res_integral_count,
    output logic                        res_last_bin
);

    logic [ihb_pkg::BCNT_W-1:0] bin_count_reg;
    logic [ihb_pkg::LWID_W-1:0] line_width_reg;

    logic [ihb_pkg::PIX_W-1:0]  pixel_reg;
    logic [ihb_pkg::THR_W-1:0]  thr_reg;
    logic                       found_reg;
    logic [ihb_pkg::BIN_W-1:0]  k_reg;
    logic [ihb_pkg::COL_W-1:0]  col_reg;
    logic [ihb_pkg::ROW_W-1:0]  row_reg;
    logic [ihb_pkg::RUN_W-1:0]  counts_reg [ihb_pkg::MAX_BINS];
    logic [ihb_pkg::CNT_W-1:0]  rd_data_reg;

    logic                       out_valid_reg;
    logic [ihb_pkg::BIN_W-1:0]  out_bin_reg;
    logic [ihb_pkg::CNT_W-1:0]  out_count_reg;
    logic                       out_last_reg;

    logic [ihb_pkg::CNT_W-1:0]  line_mem [ihb_pkg::MEM_DEPTH];

    logic [ihb_pkg::BIN_W-1:0]  bins_m1;
    logic [ihb_pkg::LWID_W-1:0] width_eff;
    logic [ihb_pkg::THR_W-1:0]  bw;
    logic                       last;
    logic                       hit;
    logic [ihb_pkg::RUN_W-1:0]  cnt_cur;
    logic [ihb_pkg::RUN_W-1:0]  cnt_new;
    logic [ihb_pkg::CNT_W-1:0]  above;
    logic [ihb_pkg::CNT_W:0]    sum;
    logic [ihb_pkg::CNT_W-1:0]  val;
    logic [ihb_pkg::BIN_W-1:0]  rd_k;
    logic [ihb_pkg::ADDR_W-1:0] rd_addr;
    logic [ihb_pkg::ADDR_W-1:0] wr_addr;
    logic [ihb_pkg::LWID_W-1:0] col_inc;
    logic [ihb_pkg::ROW_W:0]    row_inc;
    logic [ihb_pkg::ROW_W-1:0]  row_adv;

    // effective register values
    always_comb
    begin
        if (bin_count_reg == '0)
        begin
            bins_m1 = '0;
        end
        else if (bin_count_reg > ihb_pkg::BCNT_W'(ihb_pkg::MAX_BINS))
        begin
            bins_m1 = ihb_pkg::BIN_W'(ihb_pkg::MAX_BINS - 1);
        end
        else
        begin
            bins_m1 = ihb_pkg::BIN_W'(bin_count_reg - 1'b1);
        end

        if (line_width_reg == '0)
        begin
            width_eff = ihb_pkg::LWID_W'(1);
        end
        else if (line_width_reg > ihb_pkg::LWID_W'(ihb_pkg::MAX_WIDTH))
        begin
            width_eff = ihb_pkg::LWID_W'(ihb_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = line_width_reg;
        end
    end

    assign bw   = ihb_pkg::bin_span(bins_m1);
    assign last = (k_reg == bins_m1);

    // bin k is the pixel's bin if the pixel lies below (k+1)*bw or k is the last bin, first match wins
    assign hit     = !found_reg && (({1'b0, pixel_reg} < thr_reg) || last);
    assign cnt_cur = counts_reg[k_reg];
    assign cnt_new = (hit && (cnt_cur != '1)) ? cnt_cur + 1'b1 : cnt_cur;
    assign above   = (row_reg == '0) ? '0 : rd_data_reg;
    assign sum     = {1'b0, above} + (ihb_pkg::CNT_W + 1)'(cnt_new);
    assign val     = sum[ihb_pkg::CNT_W] ? '1 : sum[ihb_pkg::CNT_W-1:0];

    assign rd_k    = cmd.fire ? k_reg + 1'b1 : k_reg;
    assign rd_addr = {rd_k, col_reg};
    assign wr_addr = {k_reg, col_reg};

    assign col_inc = ihb_pkg::LWID_W'(col_reg) + 1'b1;
    assign row_inc = (ihb_pkg::ROW_W + 1)'(row_reg) + 1'b1;
    assign row_adv = (row_inc >= (ihb_pkg::ROW_W + 1)'(ihb_pkg::MAX_HEIGHT)) ?
                     '0 : row_inc[ihb_pkg::ROW_W-1:0];

    assign sts.last     = last;
    assign sts.out_free = !out_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg  <= ihb_pkg::BIN_COUNT_RST;
            line_width_reg <= ihb_pkg::LINE_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ihb_pkg::CFG_BIN_COUNT:  bin_count_reg  <= cfg_data[ihb_pkg::BCNT_W-1:0];
                ihb_pkg::CFG_LINE_WIDTH: line_width_reg <= cfg_data[ihb_pkg::LWID_W-1:0];
                default:                 bin_count_reg  <= bin_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < ihb_pkg::MAX_BINS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.accept)
            begin
                if (pix_frame_start)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (ihb_pkg::LWID_W'(col_reg) >= width_eff)
                begin
                    col_reg <= '0;
                    row_reg <= row_adv;
                end
            end
            if (cmd.prep && (col_reg == '0))
            begin
                for (int i = 0; i < ihb_pkg::MAX_BINS; i++)
                begin
                    counts_reg[i] <= '0;
                end
            end
            if (cmd.fire)
            begin
                counts_reg[k_reg] <= cnt_new;
                if (last)
                begin
                    if (col_inc >= width_eff)
                    begin
                        col_reg <= '0;
                        row_reg <= row_adv;
                    end
                    else
                    begin
                        col_reg <= col_inc[ihb_pkg::COL_W-1:0];
                    end
                end
            end
        end
    end

    // sweep state for the current pixel
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pixel_reg <= pix_pixel;
            k_reg     <= '0;
        end
        if (cmd.prep)
        begin
            found_reg <= 1'b0;
            thr_reg   <= bw;
        end
        if (cmd.fire)
        begin
            k_reg     <= k_reg + 1'b1;
            found_reg <= found_reg || hit;
            thr_reg   <= thr_reg + bw;
        end
    end

    // line store of the previous row's integrals
    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            line_mem[wr_addr] <= val;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            out_bin_reg   <= k_reg;
            out_count_reg <= val;
            out_last_reg  <= last;
        end
    end

    assign res_valid          = out_valid_reg;
    assign res_bin_index      = out_bin_reg;
    assign res_integral_count = out_count_reg;
    assign res_last_bin       = out_last_reg;

endmodule

/* src/integral_histogram_builder.sv */
// Sequence: a pixel beat is accepted in S_IDLE, the line store is prefetched in
// S_PREP, then S_RUN sweeps one bin per cycle while the result register is free,
// each with one read and one write of the line store; the next pixel waits for S_IDLE.
// Reset: control, positions, row counts and config clear asynchronously; the
// line store is not initialized and is valid only where written in this frame.
`include "assert_macros.svh"

module integral_histogram_builder (
    input  logic                       clk,
    input  logic                       rst_n,
    ihb_pix_if.sink                    pix,
    ihb_res_if.source                  res,
    input  logic                       cfg_we,
    input  logic [ihb_pkg::CIDX_W-1:0] cfg_index,
    input  logic [ihb_pkg::CFG_W-1:0]  cfg_data
);

    ihb_pkg::ihb_cmd_t cmd;
    ihb_pkg::ihb_sts_t sts;

    ihb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix.valid),
        .pix_ready (pix.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ihb_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .pix_pixel          (pix.pixel),
        .pix_frame_start    (pix.frame_start),
        .cmd                (cmd),
        .sts                (sts),
        .res_valid          (res.valid),
        .res_ready          (res.ready),
        .res_bin_index      (res.bin_index),
        .res_integral_count (res.integral_count),
        .res_last_bin       (res.last_bin)
    );

    `ASSERT_NEXT(a_accept_prefetch, clk, rst_n, cmd.accept, cmd.prep && !pix.ready)
    `ASSERT_NEXT(a_last_bin_frees, clk, rst_n, cmd.fire && sts.last, pix.ready)
    `ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.fire, sts.out_free)
    `ASSERT_NEXT(a_fire_shows_beat, clk, rst_n, cmd.fire, res.valid)

endmodule

/* dv/tb_top.sv */
// Testbench for integral_histogram_builder: directed and random frames checked beat by beat.
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT = 2000;
    localparam int COUNT_MAX   = (1 << ihb_pkg::CNT_W) - 1;

    typedef struct packed {
        logic [ihb_pkg::BIN_W-1:0] bin_index;
        logic [ihb_pkg::CNT_W-1:0] integral_count;
        logic                      last_bin;
    } integral_beat_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [ihb_pkg::CIDX_W-1:0] cfg_index;
    logic [ihb_pkg::CFG_W-1:0]  cfg_data;

    ihb_pix_if pix ();
    ihb_res_if res ();

    integral_histogram_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    int src_idle_pct;
    int snk_idle_pct;
    int stall_cycles;
    int bad_beats;

    integral_beat_t integrals_due[$];

    // predictor state
    logic [ihb_pkg::CNT_W-1:0]  above_row [ihb_pkg::MEM_DEPTH];
    logic [ihb_pkg::RUN_W-1:0]  row_counts [ihb_pkg::MAX_BINS];
    int                         col_pos;
    int                         row_pos;
    logic [ihb_pkg::BCNT_W-1:0] bins_reg;
    logic [ihb_pkg::LWID_W-1:0] width_reg;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function void next_line();
        col_pos = 0;
        row_pos = (row_pos == ihb_pkg::MAX_HEIGHT - 1) ? 0 : row_pos + 1;
    endfunction

    function void predict_integrals(input logic [ihb_pkg::PIX_W-1:0] p, input logic fs);
        int nb;
        int nw;
        int span;
        int hit;
        int idx;
        int total;
        integral_beat_t beat;
        nb = (bins_reg == 0) ? 1 :
             (bins_reg > ihb_pkg::MAX_BINS) ? ihb_pkg::MAX_BINS : int'(bins_reg);
        nw = (width_reg == 0) ? 1 :
             (width_reg > ihb_pkg::MAX_WIDTH) ? ihb_pkg::MAX_WIDTH : int'(width_reg);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else if (col_pos >= nw)
            next_line();
        if (col_pos == 0)
            foreach (row_counts[i])
                row_counts[i] = '0;
        span = 256 / nb;
        hit = int'(p) / span;
        if (hit > nb - 1)
            hit = nb - 1;
        for (int k = 0; k < nb; k++)
        begin
            idx = k * ihb_pkg::MAX_WIDTH + col_pos;
            if (k == hit && row_counts[k] != '1)
                row_counts[k] = row_counts[k] + 1'b1;
            total = ((row_pos == 0) ? 0 : int'(above_row[idx])) + int'(row_counts[k]);
            if (total > COUNT_MAX)
                total = COUNT_MAX;
            above_row[idx] = ihb_pkg::CNT_W'(total);
            beat.bin_index = ihb_pkg::BIN_W'(k);
            beat.integral_count = ihb_pkg::CNT_W'(total);
            beat.last_bin = (k == nb - 1);
            integrals_due = {integrals_due, beat};
        end
        col_pos++;
        if (col_pos >= nw)
            next_line();
    endfunction

    function void report_mismatch(input string what, input logic [31:0] want_v,
                                  input logic [31:0] got_v);
        bad_beats++;
        $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
    endfunction

    always @(posedge clk)
    begin
        integral_beat_t want;
        if (rst_n)
        begin
            if (pix.valid && pix.ready)
                predict_integrals(pix.pixel, pix.frame_start);
            if (res.valid && res.ready)
            begin
                if (integrals_due.size() == 0)
                begin
                    bad_beats++;
                    $display("%0t: beat with none expected, expected nothing, %s",
                             $time, "got bin and count");
                    $display("%0t: got bin %0d count %0d",
                             $time, res.bin_index, res.integral_count);
                end
                else
                begin
                    want = integrals_due.pop_front();
                    if (res.bin_index !== want.bin_index)
                        report_mismatch("bin_index", 32'(want.bin_index),
                                        32'(res.bin_index));
                    if (res.integral_count !== want.integral_count)
                        report_mismatch("integral_count", 32'(want.integral_count),
                                        32'(res.integral_count));
                    if (res.last_bin !== want.last_bin)
                        report_mismatch("last_bin", 32'(want.last_bin),
                                        32'(res.last_bin));
                end
            end
            if ((pix.valid && pix.ready) || (res.valid && res.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    always @(posedge clk)
        res.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [ihb_pkg::PIX_W-1:0] any_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return ihb_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [ihb_pkg::PIX_W-1:0] p, input logic fs);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= p;
        pix.frame_start <= fs;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (integrals_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [ihb_pkg::BCNT_W-1:0] nb,
                              input logic [ihb_pkg::LWID_W-1:0] nw);
        drain_results();
        repeat (3) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= ihb_pkg::CFG_BIN_COUNT;
        cfg_data <= ihb_pkg::CFG_W'(nb);
        @(posedge clk);
        cfg_index <= ihb_pkg::CFG_LINE_WIDTH;
        cfg_data <= ihb_pkg::CFG_W'(nw);
        @(posedge clk);
        cfg_we <= 1'b0;
        bins_reg = nb;
        width_reg = nw;
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd16, 1'b1);
    endtask

    task automatic test_bin_widths();
        set_config(5'd1, 11'd2);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        // 3 bins: 255 lands past the last bin and is clamped
        set_config(5'd3, 11'd2);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd170, 1'b0);
        send_pixel(8'd85, 1'b0);
    endtask

    task automatic test_register_limits();
        set_config('0, '0);
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd9, 1'b0);
        set_config(ihb_pkg::BCNT_W'((1 << ihb_pkg::BCNT_W) - 1),
                   ihb_pkg::LWID_W'((1 << ihb_pkg::LWID_W) - 1));
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
    endtask

    task automatic test_frame_restart();
        set_config(5'd5, 11'd3);
        send_pixel(8'd60, 1'b1);
        send_pixel(8'd110, 1'b0);
        send_pixel(8'd250, 1'b0);
        send_pixel(8'd60, 1'b0);
        send_pixel(8'd51, 1'b1);
        send_pixel(8'd50, 1'b0);
    endtask

    task automatic test_width_shrink();
        set_config(5'd4, 11'd4);
        send_pixel(8'd0, 1'b1);
        for (int i = 0; i < 5; i++)
            send_pixel(any_pixel(), 1'b0);
        // column is past the new width: a new row starts
        set_config(5'd4, 11'd2);
        send_pixel(any_pixel(), 1'b0);
        send_pixel(any_pixel(), 1'b0);
    endtask

    task automatic test_widest_row();
        set_config(5'd2, ihb_pkg::LWID_W'(ihb_pkg::MAX_WIDTH));
        send_pixel(any_pixel(), 1'b1);
        for (int i = 0; i < 20; i++)
            send_pixel(any_pixel(), 1'b0);
    endtask

    task automatic test_random_frames(input int item_goal);
        int sent;
        int n;
        int w;
        logic fresh;
        logic [ihb_pkg::BCNT_W-1:0] nb;
        logic [ihb_pkg::LWID_W-1:0] nw;
        sent = 0;
        while (sent < item_goal)
        begin
            fresh = 1'b0;
            if (sent == 0 || $urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 9))
                    0:       nb = '0;
                    1:       nb = ihb_pkg::BCNT_W'($urandom_range(ihb_pkg::MAX_BINS + 1,
                                                   (1 << ihb_pkg::BCNT_W) - 1));
                    2:       nb = ihb_pkg::BCNT_W'(ihb_pkg::MAX_BINS);
                    3:       nb = 5'd1;
                    default: nb = ihb_pkg::BCNT_W'($urandom_range(2, ihb_pkg::MAX_BINS - 1));
                endcase
                case ($urandom_range(0, 19))
                    0:       nw = '0;
                    1:       nw = ihb_pkg::LWID_W'($urandom_range(ihb_pkg::MAX_WIDTH,
                                                   (1 << ihb_pkg::LWID_W) - 1));
                    2:       nw = 11'd1;
                    default: nw = ihb_pkg::LWID_W'($urandom_range(2, 12));
                endcase
                set_config(nb, nw);
                fresh = 1'b1;
            end
            w = (width_reg == 0) ? 1 :
                (width_reg > ihb_pkg::MAX_WIDTH) ? ihb_pkg::MAX_WIDTH : int'(width_reg);
            n = (w <= 16) ? int'($urandom_range(1, 4 * w + 3)) : int'($urandom_range(1, 40));
            for (int i = 0; i < n; i++)
            begin
                send_pixel(any_pixel(), (i == 0 && fresh) || $urandom_range(0, 29) == 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ihb_pkg::CFG_BIN_COUNT;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.pixel = '0;
        pix.frame_start = 1'b0;
        bins_reg = ihb_pkg::BIN_COUNT_RST;
        width_reg = ihb_pkg::LINE_WIDTH_RST;
        col_pos = 0;
        row_pos = 0;
        foreach (above_row[i])
            above_row[i] = '0;
        foreach (row_counts[i])
            row_counts[i] = '0;
        src_idle_pct = 8;
        snk_idle_pct = 84;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_bin_widths();
        test_register_limits();
        test_frame_restart();
        test_width_shrink();

        src_idle_pct = 84;
        snk_idle_pct = 8;
        test_widest_row();
        test_random_frames(160);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_frames(190);

        drain_results();
        repeat (10) @(posedge clk);
        if (bad_beats == 0 && integrals_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
